@@ hw/rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 stream hasher
// Round constants, initial hash values and the front/back item type.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned WORD_W = 32;

   // One queued item: kind plus byte
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } item_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } back_state_type;

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] h;
      case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
         default: h = 32'h0;
      endcase
      return h;
   endfunction

endpackage

@@ hw/rtl/sha256_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit: SHA-256 over a byte stream
// Front queue of byte/finish items feeding a one-round-per-cycle back end.
// ----------------------------------------------------------------------------
//  channel | ports                              | moves
//  --------+------------------------------------+-------------------------
//  request | req_valid/ready, kind, data_byte   | one byte or a finish
//  result  | rsp_valid/ready, digest_word, last | one digest word
//
// The back end takes one data byte into the block buffer at a time; the 64th byte
// of a block starts the 64 rounds, one per cycle in the single round datapath,
// then an add step, and no new item is taken meanwhile. A finish runs padding
// fill and one or two compressions, then eight result transfers.
// Reset clears the queue, the bit count and loads the initial hash values.
// Until full, the queue accepts while the back end compresses or waits on rsp_ready.
module sha256_stream_hasher_unit
   import sha_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_is_last
);
   item_type in_item, q_item;
   logic     q_valid, q_ready;

   assign in_item.kind      = req_kind;
   assign in_item.data_byte = req_data_byte;

   sha_item_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (in_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   sha_core u_core (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (q_valid),
      .item_ready      (q_ready),
      .item            (q_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_is_last     (rsp_is_last)
   );
endmodule

@@ hw/rtl/sha_item_fifo.sv @@
// ----------------------------------------------------------------------------
// sha_item_fifo: front-end item queue
// Accepts items and holds up to DEPTH of them for the compression back end.
// ----------------------------------------------------------------------------
module sha_item_fifo
   import sha_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign push_ready = (cnt_ff != AW'(0) + (AW+1)'(DEPTH)) ;
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   always_comb begin
      wr_in  = push ? nxt(wr_ff) : wr_ff;
      rd_in  = pop ? nxt(rd_ff) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end
endmodule

@@ hw/rtl/sha_core.sv @@
// ----------------------------------------------------------------------------
// sha_core: block buffering, padding and the 64-round compression
// Takes one queued item at a time; emits eight digest words per finish.
// ----------------------------------------------------------------------------
module sha_core
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   output logic        item_ready,
   input  item_type    item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_is_last
);
   back_state_type state_ff, state_in;

   logic [31:0] blk_ff [16];            // block buffer as 16 big-endian words
   logic [31:0] w_ff   [16];            // schedule window, shifts each round
   logic [31:0] h_ff   [8];
   logic [31:0] v_ff   [8];
   logic [63:0] bits_ff;
   logic [63:0] len_ff;                 // length latched at finish
   logic [5:0]  pos_ff;                 // byte position while padding
   logic        fin_ff;                 // length goes into the block being filled
   logic        last_blk_ff;            // block being compressed ends a message
   logic [5:0]  t_ff;
   logic [2:0]  oidx_ff;

   logic [5:0]  used;
   logic        take;
   logic [7:0]  pad_b;
   logic [31:0] wt, s0w, s1w, s1, s0, ch, mj, t1, t2;

   assign used       = bits_ff[8:3];
   assign item_ready = (state_ff == ST_IDLE);
   assign take       = item_valid && item_ready;

   // byte written at pos_ff during padding
   always_comb begin
      if (pos_ff >= LEN_POS && !fin_ff) pad_b = 8'h00;
      else if (pos_ff >= LEN_POS)
         pad_b = len_ff[8'(63 - 8*(pos_ff - LEN_POS)) -: 8];
      else pad_b = 8'h00;
   end

   // schedule and round datapath
   always_comb begin
      s0w = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]}
            ^ (w_ff[1] >> 3);
      s1w = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
            ^ (w_ff[14] >> 10);
      wt  = (t_ff < 6'd16) ? w_ff[0] : w_ff[0] + s0w + w_ff[9] + s1w;
      s1  = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
            ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1  = v_ff[7] + s1 + ch + round_k(t_ff) + wt;
      s0  = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
            ^ {v_ff[0][21:0], v_ff[0][31:22]};
      mj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2  = s0 + mj;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (take) begin
               if (used == 6'd63)                 state_in = ST_ROUND;
               else if (item.kind == KIND_FINISH) state_in = ST_FILL;
            end
         ST_FILL:
            if (pos_ff == 6'd63) state_in = ST_ROUND;
         ST_ROUND:
            if (t_ff == 6'd63) state_in = ST_ADD;
         ST_ADD:
            if (!last_blk_ff)  state_in = ST_IDLE;
            else if (fin_ff)   state_in = ST_EMIT;
            else               state_in = ST_FILL;
         ST_EMIT:
            if (rsp_ready && oidx_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp_valid       = (state_ff == ST_EMIT);
      rsp_digest_word = h_ff[oidx_ff];
      rsp_is_last     = (oidx_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bits_ff  <= '0;
         fin_ff   <= 1'b0;
         last_blk_ff <= 1'b0;
         t_ff     <= '0;
         oidx_ff  <= '0;
         pos_ff   <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE:
               if (take) begin
                  t_ff <= '0;
                  if (item.kind == KIND_DATA) begin
                     blk_ff[used[5:2]][8'(31 - 8*used[1:0]) -: 8] <= item.data_byte;
                     bits_ff     <= bits_ff + 64'd8;
                     last_blk_ff <= 1'b0;
                  end else begin
                     blk_ff[used[5:2]][8'(31 - 8*used[1:0]) -: 8] <= PAD_BYTE;
                     len_ff      <= bits_ff;
                     // length fits in this block if at most 55 bytes held
                     fin_ff      <= (used < 6'd56);
                     last_blk_ff <= 1'b1;
                     pos_ff      <= used + 6'd1;
                  end
               end
            ST_FILL: begin
               blk_ff[pos_ff[5:2]][8'(31 - 8*pos_ff[1:0]) -: 8] <= pad_b;
               pos_ff <= pos_ff + 6'd1;
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wt;
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               t_ff <= t_ff + 6'd1;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               t_ff <= '0;
               if (last_blk_ff && !fin_ff) begin
                  // second pass: pad block carrying the length
                  fin_ff <= 1'b1;
                  pos_ff <= '0;
               end
               if (last_blk_ff && fin_ff) oidx_ff <= '0;
            end
            ST_EMIT:
               if (rsp_ready) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
                     bits_ff <= '0;
                  end
               end
            default: ;
         endcase
         // entering compression: load window and working vars
         if (state_in == ST_ROUND && state_ff != ST_ROUND) begin
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            for (int i = 0; i < 15; i++) w_ff[i] <= blk_ff[i];
            if (state_ff == ST_IDLE && item.kind == KIND_DATA)
               w_ff[15] <= {blk_ff[15][31:8], item.data_byte};
            else if (state_ff == ST_IDLE)
               w_ff[15] <= {blk_ff[15][31:8], PAD_BYTE};
            else
               w_ff[15] <= {blk_ff[15][31:8], pad_b};
         end
      end
   end
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams byte messages and finish commands into the hasher. A digest
// scoreboard hashes the same bytes and checks every digest word and the
// is_last flag. Random stalls hit both channels, and one long result stall
// backs up the input.
// ----------------------------------------------------------------------------

// Software SHA-256 of the accepted byte stream, plus the expected-word store
class sha_digest_scoreboard;
   logic [31:0] chain[8];
   logic [63:0] msg_bits;
   logic [7:0]  blk[64];
   logic [31:0] want_word[$];
   logic        want_last[$];
   int          mismatches;
   int          words_seen;

   function new();
      mismatches = 0;
      words_seen = 0;
      restart();
   endfunction

   function void restart();
      chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
      chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
      chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
      chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
      msg_bits = '0;
   endfunction

   function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function logic [31:0] kconst(int t);
      logic [31:0] k[64];
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
   endfunction

   function void compress();
      logic [31:0] w[16];
      logic [31:0] v[8];
      logic [31:0] wt, s0, s1, t1, t2;
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
         end else begin
            s0 = rotr(w[(t-15)%16], 7) ^ rotr(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
            s1 = rotr(w[(t-2)%16], 17) ^ rotr(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
            wt = w[t%16] + s0 + w[(t-7)%16] + s1;
         end
         w[t%16] = wt;
         s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
         t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + wt;
         s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
         t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endfunction

   function void note_input(logic kind, logic [7:0] data_byte);
      int          fill;
      logic [63:0] len;
      fill = int'(msg_bits[8:3]);
      if (kind == sha_pkg::KIND_DATA) begin
         blk[fill] = data_byte;
         msg_bits += 64'd8;
         if (fill == 63) compress();
         return;
      end
      len = msg_bits;
      blk[fill] = sha_pkg::PAD_BYTE;
      fill++;
      if (fill > 56) begin
         while (fill < 64) blk[fill++] = 8'h00;
         compress();
         fill = 0;
      end
      while (fill < 56) blk[fill++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         want_word.push_back(chain[i]);
         want_last.push_back(i == 7);
      end
      restart();
   endfunction

   function void check_word(logic [31:0] word, logic last);
      logic [31:0] ew;
      logic        el;
      words_seen++;
      if (want_word.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected digest word %h last %b", word, last);
         return;
      end
      ew = want_word.pop_front();
      el = want_last.pop_front();
      if (word !== ew || last !== el) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: digest word exp %h last %b, got %h last %b", ew, el, word, last);
      end
   endfunction

   function int pending();
      return want_word.size();
   endfunction
endclass

module testbench;
   import sha_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_DATA;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic        rsp_is_last;

   sha_digest_scoreboard sb = new();

   int  cycle_count = 0;
   int  items_sent = 0;
   int  messages_sent = 0;
   int  long_hold = 0;   // receiver hold-off requested by the sender thread
   int  stall_left = 0;
   bit  quiet = 1'b0;    // no idling in the final stretch

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_COUNT  = 430;

   sha256_stream_hasher_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_digest_word(rsp_digest_word), .rsp_is_last(rsp_is_last)
   );

   always #1 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: ready changes on the falling edge, one assignment per step.
   // A long hold-off is counted here, independent of the sender.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Each result transfer is checked at the edge that takes it
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_digest_word, rsp_is_last);
   end

   // Offer one item and hold it until the transfer happens
   task automatic send_item(logic kind, logic [7:0] data_byte);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= data_byte;
      do @(posedge clock); while (!req_ready);
      sb.note_input(kind, data_byte);
      items_sent++;
      if (kind == KIND_FINISH) messages_sent++;
   endtask

   task automatic idle_for(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 15));
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++) begin
         send_item(KIND_DATA, 8'($urandom_range(0, 255)));
         maybe_gap();
      end
      // payload byte on a finish is don't-care; randomize it anyway
      send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
      maybe_gap();
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   int lens[9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
   int len;

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty message with a nonzero byte on the finish,
      // then extreme byte values and the pad byte as data, then a second empty message
      send_item(KIND_FINISH, 8'hff);
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_DATA, 8'hff);
      send_item(KIND_DATA, 8'h80);
      send_item(KIND_FINISH, 8'h00);
      send_item(KIND_FINISH, 8'h00);
      // sender waits for every digest before going on
      drain();

      // Long result stall while messages keep coming: the input must back up
      long_hold = 600;
      send_message(3);
      send_message(20);
      send_message(0);
      drain();

      while (items_sent < ITEM_COUNT) begin
         if (items_sent >= ITEM_COUNT - 60) quiet = 1'b1;
         if ($urandom_range(0, 3) == 0) len = lens[$urandom_range(0, 8)];
         else if ($urandom_range(0, 9) == 0) len = $urandom_range(100, 140);
         else len = $urandom_range(0, 70);
         // keep the total close to the planned item count
         if (len > ITEM_COUNT - items_sent - 1) len = ITEM_COUNT - items_sent - 1;
         if (len < 0) len = 0;
         send_message(len);
      end

      drain();
      repeat (300) @(posedge clock);

      $display("%0d items, %0d messages hashed, %0d digest words checked",
               items_sent, messages_sent, sb.words_seen);
      $display("block-boundary lengths, long result stall and random stalls covered");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d words missing", sb.mismatches, sb.pending());
         $display("simulation failed");
      end
      $finish;
   end
endmodule
